@@ hdl/lrch_pkg.sv @@
// Shared types and constants for the lyric request code hash block.
package lrch_pkg;

  // Widths fixed by the item fields.
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned CODE_W = 33;

  // Key word masks and the sign boundary of the final value.
  localparam logic [WORD_W-1:0] BYTE_MASK = 32'h0000_00FF;
  localparam logic [WORD_W-1:0] SIGN_EDGE = 32'h8000_0000;

  // Base shifts of the forward and reverse multipliers (plus position parity).
  localparam logic [2:0] FWD_SHIFT_BASE = 3'd3;
  localparam logic [2:0] REV_SHIFT_BASE = 3'd4;

  // One classified byte as it travels from the front part to the back part.
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic [WORD_W-1:0] request_id;
    logic [WORD_W-1:0] key;
    logic              last;
  } entry_t;

  // Builds the key word from the id bytes; empty upper bytes take inverted lower ones.
  function automatic logic [WORD_W-1:0] key_word(input logic [WORD_W-1:0] id);
    logic [BYTE_W-1:0] b0;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b2;
    logic [BYTE_W-1:0] b3;
    logic [BYTE_W-1:0] x;
    logic [BYTE_W-1:0] y;
    b0 = id[7:0];
    b1 = id[15:8];
    b2 = id[23:16];
    b3 = id[31:24];
    x = (b2 != '0) ? b2 : ~b1;
    y = (b3 != '0) ? b3 : ~b0;
    return {b0, x, b1, y};
  endfunction

endpackage

@@ hdl/lyric_request_code_hash.sv @@
// A last byte taken into an empty block passes the queue and the multiply, accumulate
// and final steps before its code shows. Per byte the back sequencer multiplies, then
// accumulates; the final steps at each string end do the two dependent 32-bit multiplies.
// The input queue of QUEUE_DEPTH entries takes beats while the back part works.
// Reset clears the queue, the sequencer, both sums, the weight and the output beat.
module lyric_request_code_hash #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [lrch_pkg::BYTE_W-1:0]        data_byte,
  input  logic signed [lrch_pkg::WORD_W-1:0] request_id,
  input  logic                               last,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [lrch_pkg::CODE_W-1:0] code
);

  lrch_pkg::entry_t push_entry;
  lrch_pkg::entry_t head;
  logic             push;
  logic             pop;
  logic             q_empty;
  logic             q_full;

  // Front part: accept and classify.
  lrch_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .request_id (request_id),
    .last       (last),
    .q_full     (q_full),
    .q_push     (push),
    .q_entry    (push_entry)
  );

  // Queue between the two parts.
  lrch_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty),
    .full       (q_full)
  );

  // Back part: hash arithmetic and result register.
  lrch_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_head    (head),
    .q_empty   (q_empty),
    .q_pop     (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .code      (code)
  );

endmodule

@@ hdl/lrch_front.sv @@
// Front part: accepts input beats, forms the key word and pushes entries to the queue.
module lrch_front (
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [lrch_pkg::BYTE_W-1:0]  data_byte,
  input  logic signed [lrch_pkg::WORD_W-1:0] request_id,
  input  logic                         last,
  input  logic                         q_full,
  output logic                         q_push,
  output lrch_pkg::entry_t             q_entry
);

  // A beat is taken whenever the queue has room.
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // The key word only matters on the last byte, so it is formed here once.
  always_comb begin
    q_entry.data_byte  = data_byte;
    q_entry.request_id = request_id;
    q_entry.key        = last ? lrch_pkg::key_word(request_id) : '0;
    q_entry.last       = last;
  end

endmodule

@@ hdl/lrch_queue.sv @@
// Short entry queue that decouples the front part from the back part.
module lrch_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lrch_pkg::entry_t push_entry,
  input  logic             pop,
  output lrch_pkg::entry_t head,
  output logic             empty,
  output logic             full
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  lrch_pkg::entry_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CNT_W'(DEPTH));
  assign head  = entries[rd_ptr];

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  // Pointers wrap at the depth; the count tracks occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // The front never pushes into a full queue and the back never pops an empty one.
  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");
  assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst) (push && !pop) |=> !empty)
    else $error("queue empty after a lone push");

endmodule

@@ hdl/lrch_back.sv @@
// Back part: runs the two running sums per byte and the final multiplies per string.
module lrch_back (
  input  logic                              clk,
  input  logic                              rst,
  input  lrch_pkg::entry_t                  q_head,
  input  logic                              q_empty,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [lrch_pkg::CODE_W-1:0] code
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_FIN1 = 3'd3;
  localparam logic [2:0] S_FIN2 = 3'd4;

  logic [2:0]                    state;
  logic [2:0]                    state_next;
  logic [lrch_pkg::BYTE_W-1:0]   cur_byte;
  logic [lrch_pkg::WORD_W-1:0]   cur_id;
  logic [lrch_pkg::WORD_W-1:0]   cur_key;
  logic                          cur_last;
  logic [lrch_pkg::WORD_W-1:0]   fsum;
  logic [lrch_pkg::WORD_W-1:0]   rsum;
  logic [lrch_pkg::WORD_W-1:0]   weight;
  logic                          par;
  logic [lrch_pkg::WORD_W-1:0]   prod;
  logic [lrch_pkg::WORD_W-1:0]   tprod;
  logic [lrch_pkg::WORD_W-1:0]   ch_ext;
  logic [lrch_pkg::WORD_W-1:0]   vval;
  logic [2:0]                    fwd_sh;
  logic [2:0]                    rev_sh;
  logic                          out_free;
  logic                          load_out;

  // Signed byte widened to a word.
  assign ch_ext = {{(lrch_pkg::WORD_W - lrch_pkg::BYTE_W){cur_byte[lrch_pkg::BYTE_W-1]}},
                   cur_byte};
  assign fwd_sh = lrch_pkg::FWD_SHIFT_BASE + {2'b00, par};
  assign rev_sh = lrch_pkg::REV_SHIFT_BASE + {2'b00, par};

  // Output register is free when empty or being taken this cycle.
  assign out_free = !out_valid || !out_stall;
  assign load_out = (state == S_FIN2) && out_free;
  assign vval     = tprod * (rsum ^ cur_id);

  // Pop when idle, or straight after accumulating a byte that is not the last.
  assign q_pop = !q_empty && ((state == S_IDLE) || ((state == S_ACC) && !cur_last));

  // Sequencer for one byte, plus two steps at the end of a string.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (q_pop) state_next = S_MUL;
      end
      S_MUL: state_next = S_ACC;
      S_ACC: begin
        if (cur_last) begin
          state_next = S_FIN1;
        end else if (q_pop) begin
          state_next = S_MUL;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_FIN1: state_next = S_FIN2;
      S_FIN2: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control state and running sums.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fsum      <= '0;
      rsum      <= '0;
      weight    <= lrch_pkg::WORD_W'(1);
      par       <= 1'b0;
      out_valid <= 1'b0;
      cur_last  <= 1'b0;
    end else begin
      state <= state_next;
      if (q_pop) begin
        cur_last <= q_head.last;
      end
      if (state == S_MUL) begin
        fsum   <= ch_ext + fsum + (fsum << fwd_sh);
        weight <= weight + (weight << rev_sh);
        par    <= ~par;
      end
      if (state == S_ACC) begin
        rsum <= rsum + prod;
      end
      if (load_out) begin
        fsum   <= '0;
        rsum   <= '0;
        weight <= lrch_pkg::WORD_W'(1);
        par    <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: current entry, products and the result.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_byte <= q_head.data_byte;
      cur_id   <= q_head.request_id;
      cur_key  <= q_head.key;
    end
    if (state == S_MUL) begin
      prod <= ch_ext * weight;
    end
    if (state == S_FIN1) begin
      tprod <= ((rsum ^ cur_key) + (fsum | cur_id)) * (fsum | cur_key);
    end
    if (load_out) begin
      code <= {(vval > lrch_pkg::SIGN_EDGE), vval};
    end
  end

  // A pop happens only where the sequencer can take a new byte.
  assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == S_IDLE || state == S_ACC))
    else $error("pop outside idle or accumulate");
  // After a result is loaded, the sums start a fresh string.
  assert property (@(posedge clk) disable iff (rst)
    load_out |=> (fsum == '0 && rsum == '0 && weight == lrch_pkg::WORD_W'(1) && !par))
    else $error("state not cleared after a string");
  // The last byte always leads through both final multiply steps.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC && cur_last) |=> state == S_FIN1 ##1 state == S_FIN2)
    else $error("final multiply sequence broken");
  // A result is loaded only in the second final step.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_FIN2)
    else $error("result loaded outside final step");

endmodule

@@ verif/testbench.sv @@
// Testbench for the lyric request code hash block: queued byte strings in, checked codes out.
module testbench;

  // One string byte as the driver offers it, with its idle gap and drain request.
  typedef struct {
    logic [lrch_pkg::BYTE_W-1:0] value;
    logic [lrch_pkg::WORD_W-1:0] id;
    logic                        fin;
    int unsigned                 gap;
    logic                        hold;
  } byte_beat_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic [lrch_pkg::BYTE_W-1:0]        data_byte = '0;
  logic [lrch_pkg::WORD_W-1:0]        request_id = '0;
  logic                               last = 1'b0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic signed [lrch_pkg::CODE_W-1:0] code;

  // Hash state as the block should hold it between beats.
  logic [lrch_pkg::WORD_W-1:0] fwd_acc = '0;
  logic [lrch_pkg::WORD_W-1:0] rev_acc = '0;
  logic [lrch_pkg::WORD_W-1:0] rev_wt = 32'd1;
  logic                        pos_odd = 1'b0;

  byte_beat_t                         pending_beats[$];
  logic signed [lrch_pkg::CODE_W-1:0] codes_due[$];
  byte_beat_t                         nxt;
  logic                               have_next = 1'b0;
  int unsigned                        wait_left = 0;
  int unsigned                        stall_left = 0;
  logic                               quiet_rx = 1'b0;
  int unsigned                        n_errors = 0;

  lyric_request_code_hash dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .request_id (request_id),
    .last       (last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .code       (code)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Folds one byte into the sums; on the last byte it yields the code and restarts.
  function automatic logic hash_byte(input logic [lrch_pkg::BYTE_W-1:0] b,
                                     input logic [lrch_pkg::WORD_W-1:0] id,
                                     input logic fin,
                                     output logic signed [lrch_pkg::CODE_W-1:0] code_out);
    logic [lrch_pkg::WORD_W-1:0] ch;
    logic [lrch_pkg::WORD_W-1:0] key;
    logic [lrch_pkg::WORD_W-1:0] t;
    logic [lrch_pkg::WORD_W-1:0] v;
    logic [lrch_pkg::BYTE_W-1:0] hi;
    logic [lrch_pkg::BYTE_W-1:0] lo;
    int unsigned                 fsh;
    int unsigned                 rsh;
    ch = {{(lrch_pkg::WORD_W-lrch_pkg::BYTE_W){b[lrch_pkg::BYTE_W-1]}}, b};
    fsh = 32'(lrch_pkg::FWD_SHIFT_BASE) + 32'(pos_odd);
    rsh = 32'(lrch_pkg::REV_SHIFT_BASE) + 32'(pos_odd);
    fwd_acc = ch + fwd_acc + (fwd_acc << fsh);
    rev_acc = rev_acc + ch * rev_wt;
    rev_wt = rev_wt + (rev_wt << rsh);
    pos_odd = ~pos_odd;
    code_out = '0;
    if (!fin) begin
      return 1'b0;
    end
    // An empty upper id byte is replaced by the inverse of its partner byte.
    hi = (id[23:16] == 8'h00) ? ~id[15:8] : id[23:16];
    lo = (id[31:24] == 8'h00) ? ~id[7:0] : id[31:24];
    key = {id[7:0], hi, id[15:8], lo};
    t = ((rev_acc ^ key) + (fwd_acc | id)) * (fwd_acc | key);
    v = t * (rev_acc ^ id);
    code_out = {(v > lrch_pkg::SIGN_EDGE), v};
    fwd_acc = '0;
    rev_acc = '0;
    rev_wt = 32'd1;
    pos_odd = 1'b0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    n_errors++;
  endtask

  task automatic queue_beat(input logic [lrch_pkg::BYTE_W-1:0] b,
                            input logic [lrch_pkg::WORD_W-1:0] id,
                            input logic fin, input logic hold, input int unsigned gap);
    byte_beat_t beat;
    beat.value = b;
    beat.id = id;
    beat.fin = fin;
    beat.gap = gap;
    beat.hold = hold;
    pending_beats.push_back(beat);
  endtask

  // Random id in which each byte is cleared now and then to reach the key substitutions.
  function automatic logic [lrch_pkg::WORD_W-1:0] random_id();
    logic [lrch_pkg::WORD_W-1:0] id;
    id = $urandom;
    for (int k = 0; k < 4; k++) begin
      if ($urandom_range(0, 3) == 0) begin
        id[k*8 +: 8] = 8'h00;
      end
    end
    return id;
  endfunction

  // Driver: offers queued beats, predicts each accepted beat, and pauses as asked.
  always @(posedge clk) begin : drive_beats
    logic                               offering;
    logic signed [lrch_pkg::CODE_W-1:0] due_code;
    if (rst) begin
      in_valid <= 1'b0;
      have_next = 1'b0;
    end else begin
      offering = in_valid;
      if (in_valid && !in_stall) begin
        if (hash_byte(data_byte, request_id, last, due_code)) begin
          codes_due.push_back(due_code);
        end
        offering = 1'b0;
      end
      if (!offering && !have_next && pending_beats.size() != 0) begin
        nxt = pending_beats.pop_front();
        wait_left = nxt.gap;
        have_next = 1'b1;
      end
      if (!offering && have_next) begin
        if (wait_left != 0) begin
          wait_left--;
        end else if (!(nxt.hold && codes_due.size() != 0)) begin
          data_byte <= nxt.value;
          request_id <= nxt.id;
          last <= nxt.fin;
          offering = 1'b1;
          have_next = 1'b0;
        end
      end
      in_valid <= offering;
    end
  end

  // Monitor: takes each code beat after a drawn stall and checks it against the oldest one due.
  always @(posedge clk) begin : watch_codes
    logic signed [lrch_pkg::CODE_W-1:0] want;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = $urandom_range(0, 3);
    end else begin
      if (out_valid && !out_stall) begin
        if (codes_due.size() == 0) begin
          report_mismatch($sformatf("code %0d arrived with none due", code));
        end else begin
          want = codes_due.pop_front();
          if (code !== want) begin
            report_mismatch($sformatf("code %0d, expected %0d", code, want));
          end
        end
        if ($urandom_range(0, 15) == 0) begin
          quiet_rx = ~quiet_rx;
        end
        stall_left = quiet_rx ? 0 : $urandom_range(0, 3);
      end else if (out_valid && stall_left != 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  initial begin : stimulus
    int unsigned total;
    int unsigned len;
    int unsigned n_str;
    logic        quiet_tx;
    logic        hold;

    // Single-byte strings at the field extremes and the key special cases.
    queue_beat(8'h00, 32'h0000_0000, 1'b1, 1'b0, $urandom_range(0, 3));
    // A lone 0xFF byte with the largest id gives the boundary code that stays positive.
    queue_beat(8'hFF, 32'h7FFF_FFFF, 1'b1, 1'b0, $urandom_range(0, 3));
    queue_beat(8'h80, 32'h8000_0000, 1'b1, 1'b0, $urandom_range(0, 3));
    queue_beat(8'h7F, 32'hFFFF_FFFF, 1'b1, 1'b0, $urandom_range(0, 3));
    queue_beat(8'h01, 32'h0000_1234, 1'b1, 1'b0, $urandom_range(0, 3));
    queue_beat(8'hFF, 32'h00AB_00CD, 1'b1, 1'b0, 0);
    queue_beat(8'h7F, 32'h1200_3456, 1'b1, 1'b0, 0);
    // Short strings whose inner bytes carry ids that must be ignored.
    queue_beat(8'h80, 32'hFFFF_FFFF, 1'b0, 1'b0, $urandom_range(0, 3));
    queue_beat(8'h7F, 32'h1200_3456, 1'b1, 1'b0, $urandom_range(0, 3));
    queue_beat(8'h55, 32'hDEAD_BEEF, 1'b0, 1'b1, $urandom_range(0, 3));
    queue_beat(8'hAA, 32'h0000_0000, 1'b0, 1'b0, 0);
    queue_beat(8'h00, 32'h8000_0000, 1'b0, 1'b0, 0);
    queue_beat(8'hFF, 32'h7FFF_FFFF, 1'b0, 1'b0, 0);
    queue_beat(8'h33, 32'h00AB_00CD, 1'b1, 1'b0, 0);
    queue_beat(8'h80, 32'h0000_0000, 1'b0, 1'b0, 1);
    queue_beat(8'h80, 32'h0000_0000, 1'b0, 1'b0, 1);
    queue_beat(8'h80, 32'h0000_0000, 1'b1, 1'b0, 1);

    // Random strings: mostly short, some long enough to wrap the weight.
    total = 0;
    n_str = 0;
    while (total < 1050) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 6);
      quiet_tx = ($urandom_range(0, 4) == 0);
      hold = (n_str == 30) || ($urandom_range(0, 39) == 0);
      for (int i = 0; i < len; i++) begin
        queue_beat(8'($urandom_range(0, 255)), random_id(), (i == len - 1), hold && (i == 0),
                   quiet_tx ? 0 : $urandom_range(0, 3));
      end
      total += len;
      n_str++;
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Drain: all beats taken, all codes seen, then a wait for stray beats.
    while (!(pending_beats.size() == 0 && !have_next && !in_valid && codes_due.size() == 0)) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run.
  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end

endmodule

@@ files.f @@
hdl/lrch_pkg.sv
hdl/lrch_front.sv
hdl/lrch_queue.sv
hdl/lrch_back.sv
hdl/lyric_request_code_hash.sv
verif/testbench.sv
